// ----- src/rwd_pkg.sv -----
// Package for the register word to double decoder: format codes and helpers.
// No dependencies.
package rwd_pkg;

    typedef enum logic [3:0] {
        FMT_U8    = 4'd0,
        FMT_S8    = 4'd1,
        FMT_U16   = 4'd2,
        FMT_S16   = 4'd3,
        FMT_U32   = 4'd4,
        FMT_S32   = 4'd5,
        FMT_U64   = 4'd6,
        FMT_S64   = 4'd7,
        FMT_SGL   = 4'd8,
        FMT_PK8   = 4'd9,
        FMT_PK16  = 4'd10,
        FMT_PK24  = 4'd11,
        FMT_PK32  = 4'd12
    } fmt_t;

    // decoded integer kind handed to the normalizer
    typedef struct packed {
        logic        is_float;
        logic        neg;
        logic [63:0] mag;
        logic [31:0] fbits;
    } dec_t;

    // packed BCD byte to binary, 0..165
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi10;
        begin
            hi10 = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1);
            return hi10 + {4'd0, b[3:0]};
        end
    endfunction

endpackage

// ----- src/rwd_decode.sv -----
// Stages 1 to 3: word/byte reordering and field decode into sign and magnitude.
// Depends on rwd_pkg.
module rwd_decode (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [3:0]  format_code,
    input  logic        words_reversed,
    input  logic        bytes_swapped,
    input  logic [15:0] reg_word_0,
    input  logic [15:0] reg_word_1,
    input  logic [15:0] reg_word_2,
    input  logic [15:0] reg_word_3,
    output rwd_pkg::dec_t dec
);
    import rwd_pkg::*;

    logic [15:0] raw [4];
    logic [15:0] w_next [4];
    logic [15:0] w_reg [4];
    logic [3:0]  fmt_reg;
    logic [7:0]  bcd_b1_reg;
    logic [3:0]  fmt2_reg;
    logic [63:0] v_reg;
    logic [15:0] bcd_lo_reg;
    logic [15:0] bcd_hi_reg;
    logic [1:0]  n;
    logic [63:0] v_next;
    logic [7:0]  c0, c1, c2, c3;
    dec_t        dec_next;

    assign raw[0] = reg_word_0;
    assign raw[1] = reg_word_1;
    assign raw[2] = reg_word_2;
    assign raw[3] = reg_word_3;

    // reorder only the words the format uses
    always_comb
    begin
        case (format_code)
            FMT_U32, FMT_S32, FMT_SGL, FMT_PK24, FMT_PK32: n = 2'd1;
            FMT_U64, FMT_S64: n = 2'd3;
            default: n = 2'd0;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            logic [15:0] x;
            x = words_reversed ? raw[2'(n - 2'(i))] : raw[i];
            if (2'(i) > n) x = 16'd0;
            w_next[i] = bytes_swapped ? {x[7:0], x[15:8]} : x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= 4'd0;
        else if (en)
        begin
            fmt_reg <= format_code;
            w_reg   <= w_next;
        end
    end

    // BCD bytes to binary, pair them as two-digit-pair halves
    assign c0 = bcd_to_bin(w_reg[0][15:8]);
    assign c1 = bcd_to_bin(w_reg[0][7:0]);
    assign c2 = bcd_to_bin(w_reg[1][15:8]);
    assign c3 = bcd_to_bin(w_reg[1][7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt2_reg <= 4'd0;
        else if (en)
        begin
            fmt2_reg   <= fmt_reg;
            v_reg      <= {w_reg[0], w_reg[1], w_reg[2], w_reg[3]};
            bcd_hi_reg <= 16'(c0) * 16'd100 + {8'd0, c1};
            bcd_lo_reg <= 16'(c2) * 16'd100 + {8'd0, c3};
            bcd_b1_reg <= c1;
        end
    end

    // sign and magnitude per format
    always_comb
    begin
        dec_next.is_float = 1'b0;
        dec_next.neg      = 1'b0;
        dec_next.fbits    = v_reg[63:32];
        v_next            = {48'd0, v_reg[63:48]};
        case (fmt2_reg)
            FMT_U8: v_next = {56'd0, v_reg[55:48]};
            FMT_S8:
            begin
                dec_next.neg = v_reg[55];
                v_next = v_reg[55] ? {55'd0, 9'h100 - {1'b0, v_reg[55:48]}}
                                   : {56'd0, v_reg[55:48]};
            end
            FMT_S16:
            begin
                dec_next.neg = v_reg[63];
                v_next = v_reg[63] ? {47'd0, 17'h10000 - {1'b0, v_reg[63:48]}}
                                   : {48'd0, v_reg[63:48]};
            end
            FMT_U32: v_next = {32'd0, v_reg[63:32]};
            FMT_S32:
            begin
                dec_next.neg = v_reg[63];
                v_next = v_reg[63] ? {31'd0, 33'h100000000 - {1'b0, v_reg[63:32]}}
                                   : {32'd0, v_reg[63:32]};
            end
            FMT_U64: v_next = v_reg;
            FMT_S64:
            begin
                dec_next.neg = v_reg[63];
                v_next = v_reg[63] ? (~v_reg) + 64'd1 : v_reg;
            end
            FMT_SGL:  dec_next.is_float = 1'b1;
            FMT_PK8:  v_next = {56'd0, bcd_b1_reg};
            FMT_PK16: v_next = {48'd0, bcd_hi_reg};
            // first byte is padding; low byte of word 0 leads
            FMT_PK24: v_next = {32'd0, 32'(bcd_b1_reg) * 32'd10000}
                               + {48'd0, bcd_lo_reg};
            FMT_PK32: v_next = 64'(32'(bcd_hi_reg) * 32'd10000) + {48'd0, bcd_lo_reg};
            default:  v_next = {48'd0, v_reg[63:48]};
        endcase
        dec_next.mag = v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dec <= dec_next;
    end

endmodule

// ----- src/rwd_convert.sv -----
// Stages 4 and 5: leading-one search, normalize with rounding, single widening.
// Depends on rwd_pkg.
module rwd_convert (
    input  logic          clk,
    input  logic          en,
    input  rwd_pkg::dec_t dec,
    output logic [63:0]   value_bits
);
    import rwd_pkg::*;

    logic        flt_reg, neg_reg;
    logic [63:0] mag_reg;
    logic [5:0]  p_reg;
    logic [5:0]  p_next;
    logic [31:0] fb_reg;
    logic [63:0] dbl_next;
    logic [63:0] flt_next;

    // leading one position
    always_comb
    begin
        p_next = 6'd0;
        for (int i = 1; i < 64; i++)
            if (dec.mag[i]) p_next = 6'(i);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flt_reg <= dec.is_float;
            neg_reg <= dec.neg;
            mag_reg <= dec.mag;
            p_reg   <= p_next;
            fb_reg  <= dec.fbits;
        end
    end

    // normalize and round to nearest even
    always_comb
    begin
        logic [63:0]  norm;
        logic [53:0]  keep;
        logic         g, st;
        logic [10:0]  ex;
        norm = mag_reg << (6'd63 - p_reg);
        g    = norm[10];
        st   = |norm[9:0];
        keep = {1'b0, norm[63:11]} + {53'd0, g & (st | norm[11])};
        ex   = 11'd1023 + {5'd0, p_reg};
        if (keep[53])
        begin
            ex   = ex + 11'd1;
            keep = keep >> 1;
        end
        if (mag_reg == 64'd0)
            dbl_next = 64'd0;
        else
            dbl_next = {neg_reg, ex, keep[51:0]};
    end

    // single to double, exact
    always_comb
    begin
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  q;
        e = fb_reg[30:23];
        m = fb_reg[22:0];
        q = 5'd0;
        for (int i = 1; i < 23; i++)
            if (m[i]) q = 5'(i);
        if (e == 8'd0)
        begin
            if (m == 23'd0)
                flt_next = {fb_reg[31], 63'd0};
            else
                flt_next = {fb_reg[31], 11'(11'd874 + {6'd0, q}),
                            52'({29'd0, m} << (6'd52 - {1'b0, q}))};
        end
        else if (e == 8'hFF)
            flt_next = {fb_reg[31], 11'h7FF, (m != 23'd0), m[21:0], 29'd0}
                       | {12'd0, m[22], 51'd0};
        else
            flt_next = {fb_reg[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            value_bits <= flt_reg ? flt_next : dbl_next;
    end

endmodule

// ----- src/register_words_to_double.sv -----
// Register word to IEEE double decoder, top level.
// Pipeline of five register stages.
// Throughput one word per cycle while a waiting result is not stalled.
// The pipeline advances whenever its output is empty or taken; stall holds all stages.
// Reset clears the stage valid bits and format registers; data registers are not reset.
// Depends on rwd_pkg, rwd_decode, rwd_convert.
module register_words_to_double (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  format_code,
    input  logic        words_reversed,
    input  logic        bytes_swapped,
    input  logic [15:0] reg_word_0,
    input  logic [15:0] reg_word_1,
    input  logic [15:0] reg_word_2,
    input  logic [15:0] reg_word_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value_bits
);
    import rwd_pkg::*;

    logic [4:0] vld_reg;
    logic       en;
    dec_t       dec;

    // whole pipe moves unless a result is waiting and stalled
    assign en        = !(vld_reg[4] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 5'd0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    rwd_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .format_code    (format_code),
        .words_reversed (words_reversed),
        .bytes_swapped  (bytes_swapped),
        .reg_word_0     (reg_word_0),
        .reg_word_1     (reg_word_1),
        .reg_word_2     (reg_word_2),
        .reg_word_3     (reg_word_3),
        .dec            (dec)
    );

    rwd_convert u_convert (
        .clk        (clk),
        .en         (en),
        .dec        (dec),
        .value_bits (value_bits)
    );

endmodule
